FILE: src/assert_macros.svh
// Assertion macros shared by the modules of the prime counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tdpc_pkg.sv
package tdpc_pkg;

    localparam int VALUE_PORT_W = 32;
    localparam int COUNT_W      = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam int TWO           = 2;
    localparam int FIRST_DIVISOR = 3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TEST = 5'b00010,
        S_DIV  = 5'b00100,
        S_REM  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic next_div;
        logic set_verdict;
        logic verdict;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic le_one;
        logic is_two;
        logic is_even;
        logic sq_gt_v;
        logic div_last;
        logic rem_zero;
    } t_status;

endpackage

FILE: src/tdpc_ctrl.sv
`include "assert_macros.svh"

module tdpc_ctrl import tdpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   slot_free;
    t_cmd   cmd;

    assign slot_free = !r_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        cmd     = '0;
        if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_TEST;
                end
            end
            S_TEST: begin
                priority if (i_status.le_one || (i_status.is_even && !i_status.is_two)) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b0;
                    n_state         = S_DONE;
                end else if (i_status.is_two || i_status.sq_gt_v) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    cmd.start_div = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                if (i_status.rem_zero) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b0;
                    n_state         = S_DONE;
                end else begin
                    cmd.next_div = 1'b1;
                    n_state      = S_TEST;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.commit = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;
    assign o_cmd       = cmd;

    `TDPC_ASSERT_NXT(a_accept_starts_test, i_in_valid && !o_in_stall, r_state == S_TEST,
        "accepted request did not start a test")
    `TDPC_ASSERT_NXT(a_done_delivers, r_state == S_DONE && slot_free, r_valid,
        "finished request did not reach the output register")

endmodule

FILE: src/tdpc_datapath.sv
`include "assert_macros.svh"

module tdpc_datapath import tdpc_pkg::*; #(
    parameter int DATA_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [VALUE_PORT_W-1:0] i_value,
    input  logic                    i_last,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    output logic                    o_is_prime,
    output logic [COUNT_W-1:0]      o_prime_count,
    output logic                    o_run_end
);

    localparam int CW = $clog2(DATA_W);

    logic [DATA_W-1:0]  r_value;
    logic               r_last;
    logic [DATA_W-1:0]  r_div;
    logic [DATA_W+1:0]  r_sq;
    logic [DATA_W-1:0]  r_rem;
    logic [DATA_W-1:0]  r_shift;
    logic [CW-1:0]      r_cnt;
    logic               r_verdict;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_is_prime;
    logic [COUNT_W-1:0] r_prime_count;
    logic               r_run_end;

    logic [DATA_W:0]    rem_sh;
    logic [DATA_W:0]    div_ext;
    logic [DATA_W:0]    rem_sub;
    logic [DATA_W-1:0]  rem_new;
    logic [COUNT_W-1:0] count_inc;

    assign rem_sh  = {r_rem, r_shift[DATA_W-1]};
    assign div_ext = {1'b0, r_div};
    assign rem_sub = rem_sh - div_ext;
    assign rem_new = (rem_sh >= div_ext) ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];

    assign count_inc = (r_verdict && (r_count != COUNT_MAX)) ? r_count + COUNT_W'(1) : r_count;
    assign n_count   = r_last ? '0 : count_inc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value[DATA_W-1:0];
            r_last  <= i_last;
            r_div   <= DATA_W'(FIRST_DIVISOR);
            r_sq    <= (DATA_W+2)'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        if (i_cmd.start_div) begin
            r_rem   <= '0;
            r_shift <= r_value;
            r_cnt   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem   <= rem_new;
            r_shift <= {r_shift[DATA_W-2:0], 1'b0};
            r_cnt   <= r_cnt + CW'(1);
        end
        if (i_cmd.next_div) begin
            r_div <= r_div + DATA_W'(TWO);
            r_sq  <= r_sq + {r_div, 2'b00} + (DATA_W+2)'(4);
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict;
        end
        if (i_cmd.commit) begin
            r_is_prime    <= r_verdict;
            r_prime_count <= count_inc;
            r_run_end     <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign o_status.le_one   = (r_value[DATA_W-1:1] == '0);
    assign o_status.is_two   = (r_value == DATA_W'(TWO));
    assign o_status.is_even  = !r_value[0];
    assign o_status.sq_gt_v  = (r_sq > {2'b00, r_value});
    assign o_status.div_last = (r_cnt == CW'(DATA_W - 1));
    assign o_status.rem_zero = (r_rem == '0);

    assign o_is_prime    = r_is_prime;
    assign o_prime_count = r_prime_count;
    assign o_run_end     = r_run_end;

    `TDPC_ASSERT_NXT(a_rem_below_div, i_cmd.div_step, r_rem < r_div,
        "partial remainder is not below the divisor")
    `TDPC_ASSERT_NXT(a_run_end_clears, i_cmd.commit && r_last, r_count == '0,
        "prime count not cleared at the end of a run")

endmodule

FILE: src/trial_division_prime_counter.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_value, i_last
// result    out        o_valid / i_stall  o_is_prime, o_prime_count, o_run_end
//
// One request is tested at a time; a new one is taken once the previous result is registered.
// A request needing no division is loaded, tested and committed; each odd divisor tried adds
// a remainder pass over all W bits of the value, where W is the datapath width, and a check
// of the remainder; the remainder unit gives one bit per cycle.
// Reset clears the controller and the running prime count.
// A stalled result holds in the output register, the next request may be taken meanwhile, and
// its finished result waits until the output register frees.
module trial_division_prime_counter import tdpc_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [VALUE_PORT_W-1:0] i_value,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_is_prime,
    output logic [COUNT_W-1:0]      o_prime_count,
    output logic                    o_run_end
);

    localparam int DATA_W = (VALUE_BITS < VALUE_PORT_W) ? VALUE_BITS : VALUE_PORT_W;

    t_cmd    cmd;
    t_status status;

    tdpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tdpc_datapath #(
        .DATA_W (DATA_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_last        (i_last),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_is_prime    (o_is_prime),
        .o_prime_count (o_prime_count),
        .o_run_end     (o_run_end)
    );

endmodule
